// ===== rtl/ddm_pkg.sv =====
// Package: shared codes, types and reset values of the differential drive mixer.
`timescale 1ns / 1ps
`default_nettype none
package ddm_pkg;

  // Field widths of the channels
  localparam int CMD_W   = 2;
  localparam int TILT_W  = 8;
  localparam int MODE_W  = 2;
  localparam int MA_W    = 16;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;
  localparam int TMO_W   = 10;

  // Command codes of the input channel
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd2;

  // Drive mode codes of the result channel
  localparam logic [MODE_W-1:0] MODE_COAST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BRAKE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd2;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_ACCEL_CENTER     = 3'd0,
    REG_STEER_GAIN       = 3'd1,
    REG_STEER_DEADZONE   = 3'd2,
    REG_STEER_AUTHORITY  = 3'd3,
    REG_MAX_STEP         = 3'd4,
    REG_MAX_CURRENT_MA   = 3'd5,
    REG_BRAKE_CURRENT_MA = 3'd6,
    REG_LINK_TIMEOUT_MS  = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0]         RST_ACCEL_CENTER     = 8'd128;
  localparam logic signed [15:0] RST_STEER_GAIN       = 16'sd468;
  localparam logic [15:0]        RST_STEER_DEADZONE   = 16'd2621;
  localparam logic [15:0]        RST_STEER_AUTHORITY  = 16'd19661;
  localparam logic [15:0]        RST_MAX_STEP         = 16'd1638;
  localparam logic [15:0]        RST_MAX_CURRENT_MA   = 16'd12000;
  localparam logic [15:0]        RST_BRAKE_CURRENT_MA = 16'd8000;
  localparam logic [TMO_W-1:0]   RST_LINK_TIMEOUT_MS  = 10'd250;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEER,
    ST_MIX,
    ST_SCALE_L,
    ST_SCALE_R,
    ST_SCALE_END,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/ddm_in_if.sv =====
// Interface: input channel carrying reports, ticks and control steps.
`timescale 1ns / 1ps
`default_nettype none
interface ddm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ddm_pkg::CMD_W-1:0]  command;
  logic                       deadman_held;
  logic                       gas_held;
  logic                       brake_held;
  logic [ddm_pkg::TILT_W-1:0] tilt_sample;

  modport source (output valid, command, deadman_held, gas_held, brake_held, tilt_sample,
                  input ready);
  modport sink (input valid, command, deadman_held, gas_held, brake_held, tilt_sample,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/ddm_out_if.sv =====
// Interface: result channel carrying drive mode and motor currents.
`timescale 1ns / 1ps
`default_nettype none
interface ddm_out_if;
  logic                       valid;
  logic                       ready;
  logic [ddm_pkg::MODE_W-1:0] drive_mode;
  logic [ddm_pkg::MA_W-1:0]   left_current_ma;
  logic [ddm_pkg::MA_W-1:0]   right_current_ma;

  modport source (output valid, drive_mode, left_current_ma, right_current_ma,
                  input ready);
  modport sink (input valid, drive_mode, left_current_ma, right_current_ma,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/ddm_cfg_if.sv =====
// Interface: configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface ddm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ddm_pkg::CIDX_W-1:0]  index;
  logic [ddm_pkg::CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/differential_drive_mixer.sv =====
// Top level: arcade-style differential drive mixer with slew-limited ramps.
//
// Channels: in_chan takes transactions of three kinds. A remote report
// (command 0) latches the dead-man, gas and brake buttons and turns the
// tilt sample into a steer value; a tick (command 1) ages the link; a
// control step (command 2) yields one transaction on out_chan with the
// drive mode and both motor currents. Command 3 is dropped. cfg_chan
// writes the eight configuration registers and is always ready; write it
// only while the block is idle.
// Timing: one shared multiplier does all products. A tick is handled in the
// idle state; a report also passes ST_STEER. A coast or brake step passes
// ST_MIX and ST_EMIT, a drive step ST_MIX, ST_SCALE_L, ST_SCALE_R,
// ST_SCALE_END and ST_EMIT; out_chan.valid rises once ST_EMIT loads the
// output register, and in_chan.ready is low until the block is back idle.
// Stall: the result sits in an output register; a new transaction is taken
// while it waits, and a later result holds in the sequencer until the
// output register frees.
// Reset: rst_n (synchronous, active low) loads the register defaults,
// clears flags, steer, ramps and link age, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module differential_drive_mixer #(
  parameter int FRAC_BITS = 15,
  parameter int AGE_BITS  = 10
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ddm_in_if.sink     in_chan,
  ddm_out_if.source  out_chan,
  ddm_cfg_if.sink    cfg_chan
);

  localparam int F  = FRAC_BITS;
  localparam int AW = F + 2;                        // multiplier A operand
  localparam int BW = 17;                           // multiplier B operand
  localparam int PW = AW + BW;                      // product
  localparam int LW = F + 1;                        // ramp level 0..ONE
  localparam int SW = F + 2;                        // steer -ONE..ONE
  localparam int TW = ((F > 17) ? F : 17) + 3;      // mix target arithmetic
  localparam int GW = (AGE_BITS > ddm_pkg::TMO_W) ? AGE_BITS : ddm_pkg::TMO_W;

  localparam logic signed [PW-1:0] ONE_P  = {{(PW-1){1'b0}}, 1'b1} << F;
  localparam logic signed [TW-1:0] ONE_T  = {{(TW-1){1'b0}}, 1'b1} << F;
  localparam logic signed [SW-1:0] ONE_S  = {{(SW-1){1'b0}}, 1'b1} << F;
  localparam logic [PW:0]          HALF_P = {{PW{1'b0}}, 1'b1} << (F - 1);

  // Configuration registers
  logic [7:0]                 accel_center_r;
  logic signed [15:0]         steer_gain_r;
  logic [15:0]                steer_deadzone_r;
  logic [15:0]                steer_authority_r;
  logic [15:0]                max_step_r;
  logic [15:0]                max_current_ma_r;
  logic [15:0]                brake_current_ma_r;
  logic [ddm_pkg::TMO_W-1:0]  link_timeout_ms_r;

  // Block state
  ddm_pkg::state_t            state_r, state_nxt;
  logic                       deadman_r, deadman_nxt;
  logic                       gas_r, gas_nxt;
  logic                       brake_r, brake_nxt;
  logic signed [SW-1:0]       steer_r, steer_nxt;
  logic [LW-1:0]              left_level_r, left_level_nxt;
  logic [LW-1:0]              right_level_r, right_level_nxt;
  logic [AGE_BITS-1:0]        link_age_r, link_age_nxt;

  // Result staging and output register
  logic [ddm_pkg::MODE_W-1:0] res_mode_r, res_mode_nxt;
  logic [ddm_pkg::MA_W-1:0]   res_left_r, res_left_nxt;
  logic [ddm_pkg::MA_W-1:0]   res_right_r, res_right_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [ddm_pkg::MODE_W-1:0] out_mode_r;
  logic [ddm_pkg::MA_W-1:0]   out_left_r;
  logic [ddm_pkg::MA_W-1:0]   out_right_r;

  // Shared multiplier
  logic                       mul_en;
  logic signed [AW-1:0]       mul_a;
  logic signed [BW-1:0]       mul_b;
  logic signed [PW-1:0]       mul_p;

  logic                       in_acc;
  logic                       out_free;
  logic                       emit_load;
  logic signed [8:0]          centered;
  logic signed [SW-1:0]       steer_mag;
  logic signed [PW-1:0]       s_mag;
  logic [PW:0]                ma_sum;
  logic                       timed_out;
  logic [16:0]                mix_m;
  logic signed [TW-1:0]       mix_sm;
  logic signed [TW-1:0]       throttle;
  logic signed [TW-1:0]       tgt_l;
  logic signed [TW-1:0]       tgt_r;

  // Clamp a mix target to 0..ONE
  function automatic logic signed [TW-1:0] clamp_unit(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    r = v;
    if (v[TW-1]) begin
      r = '0;
    end else if (v > ONE_T) begin
      r = ONE_T;
    end
    return r;
  endfunction

  // Move a level toward its target by at most max_step
  function automatic logic [LW-1:0] ramp_step(input logic [LW-1:0] lvl,
                                              input logic signed [TW-1:0] tgt,
                                              input logic [15:0] lim_u);
    logic signed [TW-1:0] d;
    logic signed [TW-1:0] lim;
    logic signed [TW-1:0] sum;
    lim = signed'(TW'(lim_u));
    d   = tgt - signed'(TW'(lvl));
    if (d > lim) begin
      d = lim;
    end
    if (d < -lim) begin
      d = -lim;
    end
    sum = signed'(TW'(lvl)) + d;
    return sum[LW-1:0];
  endfunction

  ddm_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Handshakes
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ddm_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign emit_load      = (state_r == ddm_pkg::ST_EMIT) && out_free;

  assign out_chan.valid            = out_valid_r;
  assign out_chan.drive_mode       = out_mode_r;
  assign out_chan.left_current_ma  = out_left_r;
  assign out_chan.right_current_ma = out_right_r;

  // Shared operand values
  assign centered  = signed'({1'b0, in_chan.tilt_sample}) - signed'({1'b0, accel_center_r});
  assign steer_mag = steer_r[SW-1] ? -steer_r : steer_r;
  assign s_mag     = mul_p[PW-1] ? -mul_p : mul_p;
  assign ma_sum    = {1'b0, mul_p} + HALF_P;
  assign timed_out = (GW'(link_age_r) >= GW'(link_timeout_ms_r)) || !deadman_r;
  assign mix_m     = mul_p[F+16:F];
  assign mix_sm    = steer_r[SW-1] ? -signed'(TW'(mix_m)) : signed'(TW'(mix_m));
  assign throttle  = gas_r ? ONE_T : '0;
  assign tgt_l     = clamp_unit(throttle + mix_sm);
  assign tgt_r     = clamp_unit(throttle - mix_sm);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_center_r     <= ddm_pkg::RST_ACCEL_CENTER;
      steer_gain_r       <= ddm_pkg::RST_STEER_GAIN;
      steer_deadzone_r   <= ddm_pkg::RST_STEER_DEADZONE;
      steer_authority_r  <= ddm_pkg::RST_STEER_AUTHORITY;
      max_step_r         <= ddm_pkg::RST_MAX_STEP;
      max_current_ma_r   <= ddm_pkg::RST_MAX_CURRENT_MA;
      brake_current_ma_r <= ddm_pkg::RST_BRAKE_CURRENT_MA;
      link_timeout_ms_r  <= ddm_pkg::RST_LINK_TIMEOUT_MS;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (ddm_pkg::cfg_reg_t'(cfg_chan.index))
        ddm_pkg::REG_ACCEL_CENTER:     accel_center_r     <= cfg_chan.data[7:0];
        ddm_pkg::REG_STEER_GAIN:       steer_gain_r       <= signed'(cfg_chan.data);
        ddm_pkg::REG_STEER_DEADZONE:   steer_deadzone_r   <= cfg_chan.data;
        ddm_pkg::REG_STEER_AUTHORITY:  steer_authority_r  <= cfg_chan.data;
        ddm_pkg::REG_MAX_STEP:         max_step_r         <= cfg_chan.data;
        ddm_pkg::REG_MAX_CURRENT_MA:   max_current_ma_r   <= cfg_chan.data;
        ddm_pkg::REG_BRAKE_CURRENT_MA: brake_current_ma_r <= cfg_chan.data;
        ddm_pkg::REG_LINK_TIMEOUT_MS:
          link_timeout_ms_r <= cfg_chan.data[ddm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddm_pkg::ST_IDLE: begin
        if (in_acc && in_chan.command == ddm_pkg::CMD_REPORT) begin
          state_nxt = ddm_pkg::ST_STEER;
        end else if (in_acc && in_chan.command == ddm_pkg::CMD_STEP) begin
          state_nxt = ddm_pkg::ST_MIX;
        end
      end
      ddm_pkg::ST_STEER:     state_nxt = ddm_pkg::ST_IDLE;
      ddm_pkg::ST_MIX: begin
        if (timed_out || brake_r) begin
          state_nxt = ddm_pkg::ST_EMIT;
        end else begin
          state_nxt = ddm_pkg::ST_SCALE_L;
        end
      end
      ddm_pkg::ST_SCALE_L:   state_nxt = ddm_pkg::ST_SCALE_R;
      ddm_pkg::ST_SCALE_R:   state_nxt = ddm_pkg::ST_SCALE_END;
      ddm_pkg::ST_SCALE_END: state_nxt = ddm_pkg::ST_EMIT;
      ddm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = ddm_pkg::ST_IDLE;
        end
      end
      default:               state_nxt = ddm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and multiplier control per state
  always_comb begin
    deadman_nxt     = deadman_r;
    gas_nxt         = gas_r;
    brake_nxt       = brake_r;
    steer_nxt       = steer_r;
    left_level_nxt  = left_level_r;
    right_level_nxt = right_level_r;
    link_age_nxt    = link_age_r;
    res_mode_nxt    = res_mode_r;
    res_left_nxt    = res_left_r;
    res_right_nxt   = res_right_r;
    mul_en          = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    case (state_r)
      ddm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.command)
            ddm_pkg::CMD_REPORT: begin
              deadman_nxt  = in_chan.deadman_held;
              gas_nxt      = in_chan.gas_held;
              brake_nxt    = in_chan.brake_held;
              link_age_nxt = '0;
              mul_en       = 1'b1;
              mul_a        = AW'(centered);
              mul_b        = BW'(steer_gain_r);
            end
            ddm_pkg::CMD_TICK: begin
              if (link_age_r != '1) begin
                link_age_nxt = link_age_r + AGE_BITS'(1);
              end
            end
            ddm_pkg::CMD_STEP: begin
              mul_en = 1'b1;
              mul_a  = steer_mag;
              mul_b  = signed'({1'b0, steer_authority_r});
            end
            default: ;
          endcase
        end
      end
      // Apply dead zone and clamp to the steer product
      ddm_pkg::ST_STEER: begin
        if (s_mag < signed'(PW'(steer_deadzone_r))) begin
          steer_nxt = '0;
        end else if (mul_p > ONE_P) begin
          steer_nxt = ONE_S;
        end else if (mul_p < -ONE_P) begin
          steer_nxt = -ONE_S;
        end else begin
          steer_nxt = mul_p[SW-1:0];
        end
      end
      // Choose coast, brake or drive; ramp the levels on drive
      ddm_pkg::ST_MIX: begin
        if (timed_out) begin
          left_level_nxt  = '0;
          right_level_nxt = '0;
          res_mode_nxt    = ddm_pkg::MODE_COAST;
          res_left_nxt    = '0;
          res_right_nxt   = '0;
        end else if (brake_r) begin
          left_level_nxt  = '0;
          right_level_nxt = '0;
          res_mode_nxt    = ddm_pkg::MODE_BRAKE;
          res_left_nxt    = brake_current_ma_r;
          res_right_nxt   = brake_current_ma_r;
        end else begin
          left_level_nxt  = ramp_step(left_level_r, tgt_l, max_step_r);
          right_level_nxt = ramp_step(right_level_r, tgt_r, max_step_r);
          res_mode_nxt    = ddm_pkg::MODE_DRIVE;
        end
      end
      ddm_pkg::ST_SCALE_L: begin
        mul_en = 1'b1;
        mul_a  = signed'({1'b0, left_level_r});
        mul_b  = signed'({1'b0, max_current_ma_r});
      end
      ddm_pkg::ST_SCALE_R: begin
        res_left_nxt = ma_sum[F+15:F];
        mul_en       = 1'b1;
        mul_a        = signed'({1'b0, right_level_r});
        mul_b        = signed'({1'b0, max_current_ma_r});
      end
      ddm_pkg::ST_SCALE_END: begin
        res_right_nxt = ma_sum[F+15:F];
      end
      default: ;
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ddm_pkg::ST_IDLE;
      deadman_r     <= 1'b0;
      gas_r         <= 1'b0;
      brake_r       <= 1'b0;
      steer_r       <= '0;
      left_level_r  <= '0;
      right_level_r <= '0;
      link_age_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      deadman_r     <= deadman_nxt;
      gas_r         <= gas_nxt;
      brake_r       <= brake_nxt;
      steer_r       <= steer_nxt;
      left_level_r  <= left_level_nxt;
      right_level_r <= right_level_nxt;
      link_age_r    <= link_age_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_mode_r  <= res_mode_nxt;
    res_left_r  <= res_left_nxt;
    res_right_r <= res_right_nxt;
    if (emit_load) begin
      out_mode_r  <= res_mode_r;
      out_left_r  <= res_left_r;
      out_right_r <= res_right_r;
    end
  end

`ifndef SYNTHESIS
  a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (left_level_r <= LW'(ONE_T)) && (right_level_r <= LW'(ONE_T)))
    else $error("ramp level above full scale");

  a_steer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (steer_r <= ONE_S) && (steer_r >= -ONE_S))
    else $error("steer value outside unit range");

  a_coast_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == ddm_pkg::MODE_COAST) |->
      (out_left_r == '0) && (out_right_r == '0))
    else $error("coast result carries current");

  a_report_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.command == ddm_pkg::CMD_REPORT) |=> (link_age_r == '0))
    else $error("report did not clear link age");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ddm_pkg::ST_EMIT))
    else $error("result loaded outside emit state");
`endif

endmodule
`default_nettype wire

// ===== rtl/ddm_mul.sv =====
// Shared signed multiplier with registered product, used for every product of the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ddm_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [AW-1:0]    a,
  input  wire logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0]      p_r
);

  // Capture the product when the sequencer issues an operation; hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule
`default_nettype wire
